FILE: sv/ddsf_pkg.sv
package ddsf_pkg;

   localparam int unsigned FIFO_DEPTH_DEF = 64;

   localparam int unsigned ACTION_W = 3;
   localparam int unsigned DATA_W   = 16;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DMA8    = 3'd0,
      ACT_DMA16   = 3'd1,
      ACT_TICK    = 3'd2,
      ACT_CTRL8   = 3'd3,
      ACT_CTRL16  = 3'd4,
      ACT_FIFOCTL = 3'd5,
      ACT_DACCTL  = 3'd6,
      ACT_STATUS  = 3'd7
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 2'd0,
      CSR_LEN8  = 2'd1,
      CSR_LEN16 = 2'd2,
      CSR_RATE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // line flag bit positions
   localparam int unsigned FL_DRQ8   = 0;
   localparam int unsigned FL_DRQ16  = 1;
   localparam int unsigned FL_IRQ8   = 2;
   localparam int unsigned FL_IRQ16  = 3;
   localparam int unsigned FL_INT0   = 4;
   localparam int unsigned FL_INT1   = 5;
   localparam int unsigned FL_DONE8  = 6;
   localparam int unsigned FL_DONE16 = 7;

   // mode bit positions
   localparam int unsigned MD_DAC16   = 0;
   localparam int unsigned MD_SILENCE = 1;
   localparam int unsigned MD_DONEINT = 2;
   localparam int unsigned MD_SIGN8   = 4;
   localparam int unsigned MD_SIGN16  = 5;
   localparam int unsigned MD_MONO8   = 6;
   localparam int unsigned MD_MONO16  = 7;

   // control byte bit positions
   localparam int unsigned CB_STOP  = 1;
   localparam int unsigned CB_LOAD  = 2;
   localparam int unsigned CB_IRQ   = 7;
   localparam int unsigned FC_EN    = 0;
   localparam int unsigned FC_RESET = 2;
   localparam int unsigned DC_CLRINT = 6;

   localparam logic [15:0] SIGN16 = 16'h8000;
   localparam logic [7:0]  SIGN8  = 8'h80;

endpackage

FILE: sv/dma_dac_sample_fifo_top.sv
// Playback DMA and DAC sample FIFO. Each request item carries an action and a data word and
// yields exactly one response item with the held left/right DAC samples, a sample_valid strobe
// and the DMA request, interrupt and done line levels after that action. The accept edge
// reads the FIFO memory into a read register and enters execute; the commit edge does the
// read-modify-write and loads the response, stalling while the last response is not taken.
// Until that response is loaded the request side is not ready, so items do not overlap.
// FIFO memory contents are undefined after reset until written. Configuration registers are
// written through csr_wr_en/csr_index/csr_wr_data only while idle (user's duty, not checked).
module dma_dac_sample_fifo_top #(
   parameter int unsigned FIFO_DEPTH = ddsf_pkg::FIFO_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ddsf_pkg::ACTION_W-1:0]      req_action,
   input  logic [ddsf_pkg::DATA_W-1:0]        req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_left_sample,
   output logic [15:0]                        rsp_right_sample,
   output logic                               rsp_sample_valid,
   output logic                               rsp_drq_8bit,
   output logic                               rsp_drq_16bit,
   output logic                               rsp_host_irq_8bit,
   output logic                               rsp_host_irq_16bit,
   output logic                               rsp_mcu_int0,
   output logic                               rsp_mcu_int1,
   output logic                               rsp_done_8bit,
   output logic                               rsp_done_16bit,
   output logic                               rsp_fifo_byte_ready,
   input  logic                               csr_wr_en,
   input  logic [ddsf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddsf_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);
   localparam logic [IDX_W-1:0] WI_RESET = IDX_W'(1 % FIFO_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(FIFO_DEPTH);

   logic [ddsf_pkg::WORD_W-1:0] mem [FIFO_DEPTH];
   logic [ddsf_pkg::WORD_W-1:0] rd_data_ff;
   logic                        mem_we;
   logic [ddsf_pkg::WORD_W-1:0] mem_wd;

   ddsf_pkg::state_type  state_ff;
   ddsf_pkg::action_type act_ff;
   logic [7:0]           byte_ff;
   logic [15:0]          word_ff;

   logic [7:0]  mode_ff;
   logic [15:0] len8_ff;
   logic [15:0] len16_ff;
   logic [7:0]  rate_ff;

   logic [IDX_W-1:0] wi_ff, wi_in, wi_nxt;
   logic [IDX_W-1:0] ri_ff, ri_in, ri_nxt;
   logic             ht_ff, ht_in;
   logic             ct_ff, ct_in;
   logic [15:0]      cnt8_ff, cnt8_in;
   logic [15:0]      cnt16_ff, cnt16_in;
   logic [7:0]       ctl8_ff, ctl8_in;
   logic [7:0]       ctl16_ff, ctl16_in;
   logic [7:0]       fctl_ff, fctl_in;
   logic [7:0]       flags_ff, flags_in;
   logic [31:0]      last_ff, last_in;
   logic             svalid_ff, svalid_in;
   logic             fbr_ff, fbr_in;
   logic             rsp_valid_ff;

   logic accept;
   logic commit;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W:0]   diff_sum;
   logic [IDX_W:0]   diff;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ddsf_pkg::ST_IDLE);
   assign commit    = (state_ff == ddsf_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rd_addr   = (ddsf_pkg::action_type'(req_action) == ddsf_pkg::ACT_TICK) ? ri_ff : wi_ff;
   assign wi_nxt    = (wi_ff == IDX_LAST) ? '0 : wi_ff + IDX_W'(1);
   assign ri_nxt    = (ri_ff == IDX_LAST) ? '0 : ri_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (mem_we) begin
         mem[wi_ff] <= mem_wd;
      end
   end

   always_comb begin
      logic        go;
      logic        fin8;
      logic        fin16;
      logic        stereo;
      logic        start;
      logic [15:0] cnt_dec;
      logic [15:0] l16;
      logic [15:0] r16;
      logic [7:0]  l8;
      logic [7:0]  r8;
      logic [1:0]  lane;
      logic [15:0] ld_val;
      wi_in     = wi_ff;
      ri_in     = ri_ff;
      ht_in     = ht_ff;
      ct_in     = ct_ff;
      cnt8_in   = cnt8_ff;
      cnt16_in  = cnt16_ff;
      ctl8_in   = ctl8_ff;
      ctl16_in  = ctl16_ff;
      fctl_in   = fctl_ff;
      flags_in  = flags_ff;
      last_in   = last_ff;
      svalid_in = 1'b0;
      mem_we    = 1'b0;
      mem_wd    = rd_data_ff;
      go        = 1'b0;
      fin8      = 1'b0;
      fin16     = 1'b0;
      cnt_dec   = '0;
      l16       = '0;
      r16       = '0;
      l8        = '0;
      r8        = '0;
      lane      = {ct_ff, ht_ff};
      ld_val    = '0;
      stereo    = (!mode_ff[ddsf_pkg::MD_MONO8] && !mode_ff[ddsf_pkg::MD_DAC16]) ||
                  (!mode_ff[ddsf_pkg::MD_MONO16] && mode_ff[ddsf_pkg::MD_DAC16]);
      start     = !ctl8_ff[ddsf_pkg::CB_STOP] || !ctl16_ff[ddsf_pkg::CB_STOP] ||
                  mode_ff[ddsf_pkg::MD_SILENCE];
      case (act_ff)
         ddsf_pkg::ACT_DMA8: begin
            if (!ctl8_ff[ddsf_pkg::CB_STOP]) begin
               mem_we = 1'b1;
               mem_wd[{lane, 3'b000} +: 8] = byte_ff;
               go = 1'b1;
               if (mode_ff[ddsf_pkg::MD_DAC16]) begin
                  ht_in = ~ht_ff;
                  if (!ht_ff) go = 1'b0;
               end
               if (go && stereo) begin
                  ct_in = ~ct_ff;
                  if (!ct_ff) go = 1'b0;
               end
               fin8 = go;
            end
         end
         ddsf_pkg::ACT_DMA16: begin
            if (!ctl16_ff[ddsf_pkg::CB_STOP]) begin
               mem_we = 1'b1;
               if (ct_ff) mem_wd[31:16] = word_ff;
               else mem_wd[15:0] = word_ff;
               go = 1'b1;
               if (!mode_ff[ddsf_pkg::MD_MONO16]) begin
                  ct_in = ~ct_ff;
                  if (!ct_ff) go = 1'b0;
               end
               fin16 = go;
            end
         end
         ddsf_pkg::ACT_TICK: begin
            if (start && (rate_ff != 8'd0)) begin
               if (mode_ff[ddsf_pkg::MD_SILENCE]) begin
                  flags_in[ddsf_pkg::FL_INT0] = 1'b1;
               end else begin
                  if (mode_ff[ddsf_pkg::MD_DAC16]) begin
                     l16 = rd_data_ff[15:0];
                     r16 = mode_ff[ddsf_pkg::MD_MONO16] ? rd_data_ff[15:0] : rd_data_ff[31:16];
                     if (mode_ff[ddsf_pkg::MD_SIGN16]) begin
                        l16 = l16 ^ ddsf_pkg::SIGN16;
                        r16 = r16 ^ ddsf_pkg::SIGN16;
                     end
                  end else begin
                     l8 = rd_data_ff[7:0];
                     r8 = mode_ff[ddsf_pkg::MD_MONO8] ? rd_data_ff[7:0] : rd_data_ff[23:16];
                     if (mode_ff[ddsf_pkg::MD_SIGN8]) begin
                        l8 = l8 ^ ddsf_pkg::SIGN8;
                        r8 = r8 ^ ddsf_pkg::SIGN8;
                     end
                     l16 = {l8, 8'h00};
                     r16 = {r8, 8'h00};
                  end
                  last_in   = {r16, l16};
                  svalid_in = 1'b1;
                  if (!ctl8_ff[ddsf_pkg::CB_STOP]) flags_in[ddsf_pkg::FL_DRQ8] = 1'b1;
                  if (!ctl16_ff[ddsf_pkg::CB_STOP]) flags_in[ddsf_pkg::FL_DRQ16] = 1'b1;
                  if ((!ctl8_ff[ddsf_pkg::CB_STOP] && !mode_ff[ddsf_pkg::MD_DAC16]) ||
                      (!ctl16_ff[ddsf_pkg::CB_STOP] && mode_ff[ddsf_pkg::MD_DAC16])) begin
                     ri_in = ri_nxt;
                  end
               end
            end
         end
         ddsf_pkg::ACT_CTRL8: begin
            if (byte_ff[ddsf_pkg::CB_LOAD]) begin
               ld_val = mode_ff[ddsf_pkg::MD_MONO8] ? len8_ff : {1'b0, len8_ff[15:1]};
               cnt8_in = ld_val + 16'd1;
               flags_in[ddsf_pkg::FL_DONE8] = 1'b0;
            end
            if (byte_ff[ddsf_pkg::CB_STOP]) flags_in[ddsf_pkg::FL_DRQ8] = 1'b0;
            if (byte_ff[ddsf_pkg::CB_IRQ]) flags_in[ddsf_pkg::FL_IRQ8] = 1'b1;
            ctl8_in = byte_ff;
         end
         ddsf_pkg::ACT_CTRL16: begin
            if (byte_ff[ddsf_pkg::CB_LOAD]) begin
               ld_val = mode_ff[ddsf_pkg::MD_MONO16] ? len16_ff : {1'b0, len16_ff[15:1]};
               cnt16_in = ld_val + 16'd1;
               flags_in[ddsf_pkg::FL_DONE16] = 1'b0;
            end
            if (byte_ff[ddsf_pkg::CB_STOP]) flags_in[ddsf_pkg::FL_DRQ16] = 1'b0;
            if (byte_ff[ddsf_pkg::CB_IRQ]) flags_in[ddsf_pkg::FL_IRQ16] = 1'b1;
            ctl16_in = byte_ff;
         end
         ddsf_pkg::ACT_FIFOCTL: begin
            if ((fctl_ff[ddsf_pkg::FC_EN] && !byte_ff[ddsf_pkg::FC_EN]) ||
                byte_ff[ddsf_pkg::FC_RESET]) begin
               wi_in = WI_RESET;
               ri_in = '0;
               ct_in = 1'b0;
               ht_in = 1'b0;
            end
            fctl_in = byte_ff;
         end
         ddsf_pkg::ACT_DACCTL: begin
            if (byte_ff[ddsf_pkg::DC_CLRINT]) begin
               flags_in[ddsf_pkg::FL_INT0] = 1'b0;
               flags_in[ddsf_pkg::FL_INT1] = 1'b0;
            end
         end
         ddsf_pkg::ACT_STATUS: begin
            flags_in[ddsf_pkg::FL_IRQ8]  = 1'b0;
            flags_in[ddsf_pkg::FL_IRQ16] = 1'b0;
         end
         default: begin
            flags_in = flags_ff;
         end
      endcase

      // word complete: count down, then end the transfer or advance the write index
      if (fin8 || fin16) begin
         cnt_dec = (fin8 ? cnt8_ff : cnt16_ff) - 16'd1;
         if (fin8) cnt8_in = cnt_dec;
         else cnt16_in = cnt_dec;
         if (cnt_dec == 16'd0) begin
            if (fin8) flags_in[ddsf_pkg::FL_DONE8] = 1'b1;
            else flags_in[ddsf_pkg::FL_DONE16] = 1'b1;
            if (mode_ff[ddsf_pkg::MD_DONEINT]) flags_in[ddsf_pkg::FL_INT1] = 1'b1;
            if (fin8) flags_in[ddsf_pkg::FL_DRQ8] = 1'b0;
            else flags_in[ddsf_pkg::FL_DRQ16] = 1'b0;
         end else begin
            wi_in = wi_nxt;
            if (fctl_ff[ddsf_pkg::FC_RESET] || (wi_nxt == ri_ff)) begin
               if (fin8) flags_in[ddsf_pkg::FL_DRQ8] = 1'b0;
               else flags_in[ddsf_pkg::FL_DRQ16] = 1'b0;
            end
         end
      end

      if (!commit) begin
         mem_we = 1'b0;
      end
   end

   assign diff_sum = {1'b0, ri_in} + DEPTH_X - {1'b0, wi_in};
   assign diff     = (diff_sum >= DEPTH_X) ? diff_sum - DEPTH_X : diff_sum;
   assign fbr_in   = (diff != (IDX_W+1)'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddsf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         len8_ff      <= '0;
         len16_ff     <= '0;
         rate_ff      <= '0;
         wi_ff        <= WI_RESET;
         ri_ff        <= '0;
         ht_ff        <= 1'b0;
         ct_ff        <= 1'b0;
         cnt8_ff      <= '0;
         cnt16_ff     <= '0;
         ctl8_ff      <= '0;
         ctl16_ff     <= '0;
         fctl_ff      <= '0;
         flags_ff     <= '0;
         last_ff      <= '0;
         svalid_ff    <= 1'b0;
         fbr_ff       <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            case (ddsf_pkg::csr_index_type'(csr_index))
               ddsf_pkg::CSR_MODE:  mode_ff  <= csr_wr_data[7:0];
               ddsf_pkg::CSR_LEN8:  len8_ff  <= csr_wr_data;
               ddsf_pkg::CSR_LEN16: len16_ff <= csr_wr_data;
               ddsf_pkg::CSR_RATE:  rate_ff  <= csr_wr_data[7:0];
               default:             mode_ff  <= mode_ff;
            endcase
         end
         case (state_ff)
            ddsf_pkg::ST_IDLE: begin
               if (accept) state_ff <= ddsf_pkg::ST_EXEC;
            end
            ddsf_pkg::ST_EXEC: begin
               if (commit) state_ff <= ddsf_pkg::ST_IDLE;
            end
            default: state_ff <= ddsf_pkg::ST_IDLE;
         endcase
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit) begin
            wi_ff     <= wi_in;
            ri_ff     <= ri_in;
            ht_ff     <= ht_in;
            ct_ff     <= ct_in;
            cnt8_ff   <= cnt8_in;
            cnt16_ff  <= cnt16_in;
            ctl8_ff   <= ctl8_in;
            ctl16_ff  <= ctl16_in;
            fctl_ff   <= fctl_in;
            flags_ff  <= flags_in;
            last_ff   <= last_in;
            svalid_ff <= svalid_in;
            fbr_ff    <= fbr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= ddsf_pkg::action_type'(req_action);
         byte_ff <= req_data[7:0];
         word_ff <= req_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_sample     = last_ff[15:0];
   assign rsp_right_sample    = last_ff[31:16];
   assign rsp_sample_valid    = svalid_ff;
   assign rsp_drq_8bit        = flags_ff[ddsf_pkg::FL_DRQ8];
   assign rsp_drq_16bit       = flags_ff[ddsf_pkg::FL_DRQ16];
   assign rsp_host_irq_8bit   = flags_ff[ddsf_pkg::FL_IRQ8];
   assign rsp_host_irq_16bit  = flags_ff[ddsf_pkg::FL_IRQ16];
   assign rsp_mcu_int0        = flags_ff[ddsf_pkg::FL_INT0];
   assign rsp_mcu_int1        = flags_ff[ddsf_pkg::FL_INT1];
   assign rsp_done_8bit       = flags_ff[ddsf_pkg::FL_DONE8];
   assign rsp_done_16bit      = flags_ff[ddsf_pkg::FL_DONE16];
   assign rsp_fifo_byte_ready = fbr_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ddsf_pkg::ST_EXEC))
      else $error("accepted item did not enter execute");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ddsf_pkg::ST_EXEC) && commit)
      else $error("memory write outside commit");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (wi_ff <= IDX_LAST) && (ri_ff <= IDX_LAST))
      else $error("fifo index out of range");

   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == ddsf_pkg::ST_IDLE))
      else $error("commit did not present response");

   a_svalid_tick: assert property (@(posedge clock) disable iff (reset)
      (commit && svalid_in) |-> (act_ff == ddsf_pkg::ACT_TICK))
      else $error("sample produced by non-tick item");

endmodule

FILE: test/dma_dac_sample_fifo_top_tb.sv
`timescale 1ns / 100ps

module dma_dac_sample_fifo_top_tb;

   localparam int unsigned DEPTH       = ddsf_pkg::FIFO_DEPTH_DEF;
   localparam int unsigned IDX_W       = $clog2(DEPTH);
   localparam int unsigned PHASES      = 12;
   localparam int unsigned PHASE_ITEMS = 139;
   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct {
      logic [15:0] left_sample;
      logic [15:0] right_sample;
      logic        sample_valid;
      logic        drq_8bit;
      logic        drq_16bit;
      logic        host_irq_8bit;
      logic        host_irq_16bit;
      logic        mcu_int0;
      logic        mcu_int1;
      logic        done_8bit;
      logic        done_16bit;
      logic        fifo_byte_ready;
   } dac_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [ddsf_pkg::ACTION_W-1:0]   req_action = '0;
   logic [ddsf_pkg::DATA_W-1:0]     req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [15:0]                     rsp_left_sample;
   logic [15:0]                     rsp_right_sample;
   logic                            rsp_sample_valid;
   logic                            rsp_drq_8bit;
   logic                            rsp_drq_16bit;
   logic                            rsp_host_irq_8bit;
   logic                            rsp_host_irq_16bit;
   logic                            rsp_mcu_int0;
   logic                            rsp_mcu_int1;
   logic                            rsp_done_8bit;
   logic                            rsp_done_16bit;
   logic                            rsp_fifo_byte_ready;
   logic                            csr_wr_en = 1'b0;
   logic [ddsf_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ddsf_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   dma_dac_sample_fifo_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_sample     (rsp_left_sample),
      .rsp_right_sample    (rsp_right_sample),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_drq_8bit        (rsp_drq_8bit),
      .rsp_drq_16bit       (rsp_drq_16bit),
      .rsp_host_irq_8bit   (rsp_host_irq_8bit),
      .rsp_host_irq_16bit  (rsp_host_irq_16bit),
      .rsp_mcu_int0        (rsp_mcu_int0),
      .rsp_mcu_int1        (rsp_mcu_int1),
      .rsp_done_8bit       (rsp_done_8bit),
      .rsp_done_16bit      (rsp_done_16bit),
      .rsp_fifo_byte_ready (rsp_fifo_byte_ready),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   always #1 clock = ~clock;

   logic [7:0]  mode_r;
   logic [15:0] len8_r;
   logic [15:0] len16_r;
   logic [7:0]  rate_r;

   logic [31:0]      store_q [DEPTH];
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   bit               half_t;
   bit               chan_t;
   logic [15:0]      cnt8;
   logic [15:0]      cnt16;
   logic [7:0]       ctl8;
   logic [7:0]       ctl16;
   logic [7:0]       fifo_ctl;
   logic [7:0]       flags;
   logic [31:0]      held_pair;

   dac_result_type pending_results [$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;
   int unsigned ready_cycle = 0;
   int unsigned ready_style = 0;

   function automatic void clear_dac_state();
      mode_r    = '0;
      len8_r    = '0;
      len16_r   = '0;
      rate_r    = '0;
      wr_idx    = IDX_W'(1);
      rd_idx    = '0;
      half_t    = 1'b0;
      chan_t    = 1'b0;
      cnt8      = '0;
      cnt16     = '0;
      ctl8      = '0;
      ctl16     = '0;
      fifo_ctl  = '0;
      flags     = '0;
      held_pair = '0;
   endfunction

   function automatic void close_word(bit wide);
      int unsigned done_bit;
      int unsigned drq_bit;
      logic [15:0] remain;
      done_bit = wide ? ddsf_pkg::FL_DONE16 : ddsf_pkg::FL_DONE8;
      drq_bit  = wide ? ddsf_pkg::FL_DRQ16 : ddsf_pkg::FL_DRQ8;
      if (wide) begin
         cnt16  = cnt16 - 16'd1;
         remain = cnt16;
      end else begin
         cnt8   = cnt8 - 16'd1;
         remain = cnt8;
      end
      if (remain == 16'd0) begin
         flags[done_bit] = 1'b1;
         if (mode_r[ddsf_pkg::MD_DONEINT])
            flags[ddsf_pkg::FL_INT1] = 1'b1;
         flags[drq_bit] = 1'b0;
      end else begin
         wr_idx = wr_idx + 1'b1;
         if (fifo_ctl[ddsf_pkg::FC_RESET] || wr_idx == rd_idx)
            flags[drq_bit] = 1'b0;
      end
   endfunction

   function automatic dac_result_type advance_dac_state(ddsf_pkg::action_type a,
                                                        logic [15:0] d);
      dac_result_type   res;
      logic [7:0]       b;
      logic [1:0]       lane;
      logic [31:0]      w;
      logic [15:0]      l;
      logic [15:0]      r;
      logic [7:0]       lb;
      logic [7:0]       rb;
      logic [IDX_W-1:0] idx_gap;
      bit               word_full;
      bit               fresh;
      bit               dac16;
      bit               stop8;
      bit               stop16;
      b      = d[7:0];
      fresh  = 1'b0;
      dac16  = mode_r[ddsf_pkg::MD_DAC16];
      stop8  = ctl8[ddsf_pkg::CB_STOP];
      stop16 = ctl16[ddsf_pkg::CB_STOP];
      case (a)
         ddsf_pkg::ACT_DMA8: begin
            if (!stop8) begin
               lane = {chan_t, half_t};
               store_q[wr_idx][lane*8 +: 8] = b;
               word_full = 1'b1;
               if (dac16) begin
                  half_t    = ~half_t;
                  word_full = !half_t;
               end
               if (word_full && (dac16 ? !mode_r[ddsf_pkg::MD_MONO16] :
                                         !mode_r[ddsf_pkg::MD_MONO8])) begin
                  chan_t    = ~chan_t;
                  word_full = !chan_t;
               end
               if (word_full)
                  close_word(1'b0);
            end
         end
         ddsf_pkg::ACT_DMA16: begin
            if (!stop16) begin
               store_q[wr_idx][chan_t*16 +: 16] = d;
               word_full = 1'b1;
               if (!mode_r[ddsf_pkg::MD_MONO16]) begin
                  chan_t    = ~chan_t;
                  word_full = !chan_t;
               end
               if (word_full)
                  close_word(1'b1);
            end
         end
         ddsf_pkg::ACT_TICK: begin
            if ((!stop8 || !stop16 || mode_r[ddsf_pkg::MD_SILENCE]) && rate_r != 8'd0) begin
               if (mode_r[ddsf_pkg::MD_SILENCE]) begin
                  flags[ddsf_pkg::FL_INT0] = 1'b1;
               end else begin
                  w = store_q[rd_idx];
                  if (dac16) begin
                     l = w[15:0];
                     r = mode_r[ddsf_pkg::MD_MONO16] ? l : w[31:16];
                     if (mode_r[ddsf_pkg::MD_SIGN16]) begin
                        l = l ^ ddsf_pkg::SIGN16;
                        r = r ^ ddsf_pkg::SIGN16;
                     end
                  end else begin
                     lb = w[7:0];
                     rb = mode_r[ddsf_pkg::MD_MONO8] ? lb : w[23:16];
                     if (mode_r[ddsf_pkg::MD_SIGN8]) begin
                        lb = lb ^ ddsf_pkg::SIGN8;
                        rb = rb ^ ddsf_pkg::SIGN8;
                     end
                     l = {lb, 8'h00};
                     r = {rb, 8'h00};
                  end
                  held_pair = {r, l};
                  if (!stop8)
                     flags[ddsf_pkg::FL_DRQ8] = 1'b1;
                  if (!stop16)
                     flags[ddsf_pkg::FL_DRQ16] = 1'b1;
                  if ((!stop8 && !dac16) || (!stop16 && dac16))
                     rd_idx = rd_idx + 1'b1;
                  fresh = 1'b1;
               end
            end
         end
         ddsf_pkg::ACT_CTRL8: begin
            if (b[ddsf_pkg::CB_LOAD]) begin
               cnt8 = (mode_r[ddsf_pkg::MD_MONO8] ? len8_r : (len8_r >> 1)) + 16'd1;
               flags[ddsf_pkg::FL_DONE8] = 1'b0;
            end
            if (b[ddsf_pkg::CB_STOP])
               flags[ddsf_pkg::FL_DRQ8] = 1'b0;
            if (b[ddsf_pkg::CB_IRQ])
               flags[ddsf_pkg::FL_IRQ8] = 1'b1;
            ctl8 = b;
         end
         ddsf_pkg::ACT_CTRL16: begin
            if (b[ddsf_pkg::CB_LOAD]) begin
               cnt16 = (mode_r[ddsf_pkg::MD_MONO16] ? len16_r : (len16_r >> 1)) + 16'd1;
               flags[ddsf_pkg::FL_DONE16] = 1'b0;
            end
            if (b[ddsf_pkg::CB_STOP])
               flags[ddsf_pkg::FL_DRQ16] = 1'b0;
            if (b[ddsf_pkg::CB_IRQ])
               flags[ddsf_pkg::FL_IRQ16] = 1'b1;
            ctl16 = b;
         end
         ddsf_pkg::ACT_FIFOCTL: begin
            if ((fifo_ctl[ddsf_pkg::FC_EN] && !b[ddsf_pkg::FC_EN]) || b[ddsf_pkg::FC_RESET]) begin
               wr_idx = IDX_W'(1);
               rd_idx = '0;
               chan_t = 1'b0;
               half_t = 1'b0;
            end
            fifo_ctl = b;
         end
         ddsf_pkg::ACT_DACCTL: begin
            if (b[ddsf_pkg::DC_CLRINT]) begin
               flags[ddsf_pkg::FL_INT0] = 1'b0;
               flags[ddsf_pkg::FL_INT1] = 1'b0;
            end
         end
         default: begin
            flags[ddsf_pkg::FL_IRQ8]  = 1'b0;
            flags[ddsf_pkg::FL_IRQ16] = 1'b0;
         end
      endcase
      idx_gap                = rd_idx - wr_idx;
      res.left_sample        = held_pair[15:0];
      res.right_sample       = held_pair[31:16];
      res.sample_valid       = fresh;
      res.drq_8bit           = flags[ddsf_pkg::FL_DRQ8];
      res.drq_16bit          = flags[ddsf_pkg::FL_DRQ16];
      res.host_irq_8bit      = flags[ddsf_pkg::FL_IRQ8];
      res.host_irq_16bit     = flags[ddsf_pkg::FL_IRQ16];
      res.mcu_int0           = flags[ddsf_pkg::FL_INT0];
      res.mcu_int1           = flags[ddsf_pkg::FL_INT1];
      res.done_8bit          = flags[ddsf_pkg::FL_DONE8];
      res.done_16bit         = flags[ddsf_pkg::FL_DONE16];
      res.fifo_byte_ready    = (idx_gap != IDX_W'(1));
      return res;
   endfunction

   task automatic push_item(ddsf_pkg::action_type a, logic [15:0] d);
      int unsigned idle;
      if (burst_left == 0) begin
         idle       = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (idle != 0) begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_action <= a;
      req_data   <= d;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(advance_dac_state(a, d));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(ddsf_pkg::csr_index_type idx, logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] m, logic [15:0] l8, logic [15:0] l16, logic [7:0] r);
      wait_idle();
      csr_put(ddsf_pkg::CSR_MODE, {8'($urandom), m});
      csr_put(ddsf_pkg::CSR_LEN8, l8);
      csr_put(ddsf_pkg::CSR_LEN16, l16);
      csr_put(ddsf_pkg::CSR_RATE, {8'($urandom), r});
      csr_wr_en <= 1'b0;
      mode_r  = m;
      len8_r  = l8;
      len16_r = l16;
      rate_r  = r;
   endtask

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      dac_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result item with nothing expected");
         end else begin
            want = pending_results.pop_front();
            check_field("left_sample", want.left_sample, rsp_left_sample);
            check_field("right_sample", want.right_sample, rsp_right_sample);
            check_field("sample_valid", 16'(want.sample_valid), 16'(rsp_sample_valid));
            check_field("drq_8bit", 16'(want.drq_8bit), 16'(rsp_drq_8bit));
            check_field("drq_16bit", 16'(want.drq_16bit), 16'(rsp_drq_16bit));
            check_field("host_irq_8bit", 16'(want.host_irq_8bit), 16'(rsp_host_irq_8bit));
            check_field("host_irq_16bit", 16'(want.host_irq_16bit),
                        16'(rsp_host_irq_16bit));
            check_field("mcu_int0", 16'(want.mcu_int0), 16'(rsp_mcu_int0));
            check_field("mcu_int1", 16'(want.mcu_int1), 16'(rsp_mcu_int1));
            check_field("done_8bit", 16'(want.done_8bit), 16'(rsp_done_8bit));
            check_field("done_16bit", 16'(want.done_16bit), 16'(rsp_done_16bit));
            check_field("fifo_byte_ready", 16'(want.fifo_byte_ready),
                        16'(rsp_fifo_byte_ready));
         end
      end
   end

   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 256 == 0)
         ready_style <= $urandom_range(0, 3);
      case (ready_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 9) < 7);
         2: rsp_ready <= (ready_cycle % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) < 2);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic test_power_up();
      push_item(ddsf_pkg::ACT_TICK, 16'hFFFF);
      push_item(ddsf_pkg::ACT_STATUS, 16'h0000);
      push_item(ddsf_pkg::ACT_DACCTL, 16'h0040);
   endtask

   // fill every entry in both halves so no tick ever reads an unwritten word
   task automatic test_fill();
      repeat (2 * DEPTH) push_item(ddsf_pkg::ACT_DMA16, 16'($urandom));
   endtask

   task automatic test_dac16_count();
      set_config(8'h01, 16'h0000, 16'h0003, 8'h01);
      push_item(ddsf_pkg::ACT_CTRL16, 16'h0004);
      push_item(ddsf_pkg::ACT_DMA16, 16'hFFFF);
      push_item(ddsf_pkg::ACT_DMA16, 16'h0000);
      push_item(ddsf_pkg::ACT_DMA16, 16'h8001);
      push_item(ddsf_pkg::ACT_DMA16, 16'h7FFE);
      push_item(ddsf_pkg::ACT_DMA16, 16'h1234);
      push_item(ddsf_pkg::ACT_DMA16, 16'hABCD);
      push_item(ddsf_pkg::ACT_TICK, 16'h0000);
   endtask

   task automatic test_wide_mono();
      set_config(8'hF5, 16'hFFFF, 16'hFFFF, 8'hFF);
      push_item(ddsf_pkg::ACT_CTRL8, 16'hFF84);
      push_item(ddsf_pkg::ACT_CTRL16, 16'h0084);
      push_item(ddsf_pkg::ACT_DMA8, 16'hFFFF);
      push_item(ddsf_pkg::ACT_DMA8, 16'h00AB);
      push_item(ddsf_pkg::ACT_TICK, 16'h0000);
      push_item(ddsf_pkg::ACT_STATUS, 16'hFFFF);
   endtask

   task automatic test_byte_sign();
      set_config(8'h10, 16'h0001, 16'h0000, 8'h80);
      push_item(ddsf_pkg::ACT_CTRL8, 16'h0004);
      push_item(ddsf_pkg::ACT_DMA8, 16'h0080);
      push_item(ddsf_pkg::ACT_DMA8, 16'hFF7F);
      push_item(ddsf_pkg::ACT_TICK, 16'h0000);
   endtask

   task automatic test_stop_silence();
      push_item(ddsf_pkg::ACT_CTRL8, 16'h0002);
      push_item(ddsf_pkg::ACT_CTRL16, 16'h0002);
      push_item(ddsf_pkg::ACT_DMA8, 16'h00FF);
      push_item(ddsf_pkg::ACT_DMA16, 16'hFFFF);
      push_item(ddsf_pkg::ACT_TICK, 16'h0000);
      set_config(8'h02, 16'h0000, 16'h0000, 8'h01);
      push_item(ddsf_pkg::ACT_TICK, 16'h0000);
      push_item(ddsf_pkg::ACT_DACCTL, 16'h0040);
   endtask

   task automatic test_fifo_control();
      push_item(ddsf_pkg::ACT_FIFOCTL, 16'h0001);
      push_item(ddsf_pkg::ACT_FIFOCTL, 16'h0000);
      push_item(ddsf_pkg::ACT_FIFOCTL, 16'h0004);
      push_item(ddsf_pkg::ACT_FIFOCTL, 16'h0000);
   endtask

   task automatic test_random();
      int unsigned pick;
      logic [7:0]  m;
      logic [7:0]  b;
      logic [15:0] l8;
      logic [15:0] l16;
      logic [7:0]  r;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            set_config(8'h00, 16'h0000, 16'h0000, 8'h00);
         end else if (phase == 1) begin
            set_config(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
         end else begin
            m = 8'($urandom);
            m[ddsf_pkg::MD_SILENCE] = m[ddsf_pkg::MD_SILENCE] & ($urandom_range(0, 3) == 0);
            l8  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            l16 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            r   = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            set_config(m, l8, l16, r);
         end
         b = 8'($urandom);
         b[ddsf_pkg::CB_LOAD] = 1'b1;
         b[ddsf_pkg::CB_STOP] = 1'b0;
         push_item(ddsf_pkg::ACT_CTRL8, {8'($urandom), b});
         b = 8'($urandom);
         b[ddsf_pkg::CB_LOAD] = 1'b1;
         b[ddsf_pkg::CB_STOP] = 1'b0;
         push_item(ddsf_pkg::ACT_CTRL16, {8'($urandom), b});
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            b = 8'($urandom);
            if (pick < 24) begin
               push_item(ddsf_pkg::ACT_DMA8, 16'($urandom));
            end else if (pick < 48) begin
               push_item(ddsf_pkg::ACT_DMA16, 16'($urandom));
            end else if (pick < 72) begin
               push_item(ddsf_pkg::ACT_TICK, 16'($urandom));
            end else if (pick < 77) begin
               if ($urandom_range(0, 3) != 0)
                  b[ddsf_pkg::CB_STOP] = 1'b0;
               push_item(ddsf_pkg::ACT_CTRL8, {8'($urandom), b});
            end else if (pick < 82) begin
               if ($urandom_range(0, 3) != 0)
                  b[ddsf_pkg::CB_STOP] = 1'b0;
               push_item(ddsf_pkg::ACT_CTRL16, {8'($urandom), b});
            end else if (pick < 87) begin
               if ($urandom_range(0, 3) != 0)
                  b[ddsf_pkg::FC_RESET] = 1'b0;
               push_item(ddsf_pkg::ACT_FIFOCTL, {8'($urandom), b});
            end else if (pick < 93) begin
               push_item(ddsf_pkg::ACT_DACCTL, 16'($urandom));
            end else begin
               push_item(ddsf_pkg::ACT_STATUS, 16'($urandom));
            end
         end
      end
   endtask

   initial begin
      clear_dac_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_power_up();
      test_fill();
      test_dac16_count();
      test_wide_mono();
      test_byte_sign();
      test_stop_silence();
      test_fifo_control();
      test_random();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
